// ----- hdl/led_matrix_frame_engine_macros.svh -----
// Assertion macros used by the frame engine checker.
`ifndef LED_MATRIX_FRAME_ENGINE_MACROS_SVH
`define LED_MATRIX_FRAME_ENGINE_MACROS_SVH

// same-cycle implication
`define LMFE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LMFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/lmfe_pkg.sv -----
// Types and constants of the LED matrix frame engine.
package lmfe_pkg;

   localparam int MAX_DIM   = 32;
   localparam int DIM_W     = 5;
   localparam int CNT_W     = 6;
   localparam int IDX_W     = 2 * DIM_W;
   localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
   localparam int CH_W      = 8;
   localparam int PIX_W     = 3 * CH_W;
   localparam int CSR_AW    = 2;

   localparam logic [CNT_W-1:0]  COLS_RESET = CNT_W'(12);
   localparam logic [CNT_W-1:0]  ROWS_RESET = CNT_W'(12);
   localparam logic [CNT_W-1:0]  DIM_MAX    = CNT_W'(MAX_DIM);
   localparam logic [CSR_AW-1:0] REG_NUM_COLS = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] REG_NUM_ROWS = CSR_AW'(1);

   localparam logic [3:0] A_PIX_SET    = 4'd0;
   localparam logic [3:0] A_PIX_ADD    = 4'd1;
   localparam logic [3:0] A_PIX_INV    = 4'd2;
   localparam logic [3:0] A_ROW_SET    = 4'd3;
   localparam logic [3:0] A_ROW_ADD    = 4'd4;
   localparam logic [3:0] A_ROW_INV    = 4'd5;
   localparam logic [3:0] A_COL_SET    = 4'd6;
   localparam logic [3:0] A_COL_ADD    = 4'd7;
   localparam logic [3:0] A_COL_INV    = 4'd8;
   localparam logic [3:0] A_ALL_SET    = 4'd9;
   localparam logic [3:0] A_ALL_ADD    = 4'd10;
   localparam logic [3:0] A_ALL_INV    = 4'd11;
   localparam logic [3:0] A_STRIP_SET  = 4'd12;
   localparam logic [3:0] A_STRIP_READ = 4'd13;
   localparam logic [3:0] A_SHOW       = 4'd14;
   localparam logic [3:0] A_DISP_READ  = 4'd15;

   typedef struct packed {
      logic [3:0]       action;
      logic [DIM_W-1:0] row;
      logic [DIM_W-1:0] col;
      logic [CNT_W-1:0] range_start;
      logic [CNT_W-1:0] range_end;
      logic [IDX_W-1:0] strip_index;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0] read_red;
      logic [CH_W-1:0] read_green;
      logic [CH_W-1:0] read_blue;
   } rsp_type;

endpackage

// ----- hdl/led_matrix_frame_engine.sv -----
// LED matrix frame engine: working/display frame stores and pixel sequencer.
//
//  port group  | handshake              | beat
//  ------------+------------------------+------------------------------
//  req_        | start & !busy          | req_data (command, operands)
//  rsp_        | rsp_strobe (one cycle) | rsp_data (read pixel or zero)
//  csr_        | csr_we                 | csr_addr, csr_wdata
//
// After reset a clearing pass zeroes all 1024 entries of both frames, busy high.
// One pixel per cycle through the shared read-modify-write path:
// pixel and read commands scan one pixel, ranges n pixels, whole/show rows*cols pixels.
// Strip commands first divide the strip index by repeated subtraction of the column count.
// The receiver cannot stall; one result follows every command.
module led_matrix_frame_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lmfe_pkg::req_type             req_data,
   output logic                          rsp_strobe,
   output lmfe_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  logic [lmfe_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [lmfe_pkg::CNT_W-1:0]    csr_wdata
);
   import lmfe_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_DIV   = 5'b00100,
      S_SCAN  = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      OP_SET, OP_ADD, OP_INV, OP_COPY, OP_READ_W, OP_READ_D
   } op_type;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [CNT_W-1:0] cols_reg_ff, rows_reg_ff;
   logic [CNT_W-1:0] cols_act, rows_act;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] y_ff, y_in, y_end_ff, y_end_in;
   logic [CNT_W-1:0] x_ff, x_in, x_start_ff, x_start_in, x_end_ff, x_end_in;
   logic [PIX_W-1:0] opnd_ff, opnd_in;
   logic [PIX_W-1:0] rd_ff, rd_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_addr_ff, pend_addr_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [PIX_W-1:0] work_mem [MEM_DEPTH];
   logic [PIX_W-1:0] disp_mem [MEM_DEPTH];
   logic [PIX_W-1:0] work_rd_ff, disp_rd_ff;
   logic             work_we, disp_we;
   logic [IDX_W-1:0] wr_addr;
   logic [PIX_W-1:0] work_wdata, disp_wdata, pix_new;

   logic             accept, issue, x_wrap;
   logic [IDX_W-1:0] scan_addr;
   logic [CNT_W-1:0] lim, rng_lo, rng_hi, rng_max, strip_col;
   logic [CH_W:0]    sum;
   logic [CH_W-1:0]  cur, opv;

   always_comb begin
      cols_act = (cols_reg_ff == '0) ? CNT_W'(1) :
                 (cols_reg_ff > DIM_MAX) ? DIM_MAX : cols_reg_ff;
      rows_act = (rows_reg_ff == '0) ? CNT_W'(1) :
                 (rows_reg_ff > DIM_MAX) ? DIM_MAX : rows_reg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_reg_ff <= COLS_RESET;
         rows_reg_ff <= ROWS_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_NUM_COLS: cols_reg_ff <= csr_wdata;
            REG_NUM_ROWS: rows_reg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign issue     = (y_ff < y_end_ff) && (x_ff < x_end_ff);
   assign x_wrap    = ((x_ff + CNT_W'(1)) == x_end_ff);
   assign scan_addr = {y_ff[DIM_W-1:0], x_ff[DIM_W-1:0]};

   // range ends: swap, then clamp the end
   always_comb begin
      lim     = (req_data.action inside {A_ROW_SET, A_ROW_ADD, A_ROW_INV}) ?
                cols_act : rows_act;
      rng_lo  = (req_data.range_start < req_data.range_end) ?
                req_data.range_start : req_data.range_end;
      rng_max = (req_data.range_start < req_data.range_end) ?
                req_data.range_end : req_data.range_start;
      rng_hi  = (rng_max > lim) ? lim : rng_max;
   end

   assign strip_col = y_ff[0] ? (cols_act - CNT_W'(1) - rem_ff[CNT_W-1:0]) :
                      rem_ff[CNT_W-1:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      clr_in        = clr_ff;
      rem_in        = rem_ff;
      y_in          = y_ff;
      y_end_in      = y_end_ff;
      x_in          = x_ff;
      x_start_in    = x_start_ff;
      x_end_in      = x_end_ff;
      opnd_in       = opnd_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = scan_addr;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(MEM_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               opnd_in    = {req_data.red, req_data.green, req_data.blue};
               state_in   = S_SCAN;
               y_in       = '0;
               y_end_in   = '0;
               x_in       = '0;
               x_start_in = '0;
               x_end_in   = '0;
               case (req_data.action)
                  A_PIX_SET, A_ROW_SET, A_COL_SET, A_ALL_SET, A_STRIP_SET: op_in = OP_SET;
                  A_PIX_ADD, A_ROW_ADD, A_COL_ADD, A_ALL_ADD: op_in = OP_ADD;
                  A_PIX_INV, A_ROW_INV, A_COL_INV, A_ALL_INV: op_in = OP_INV;
                  A_STRIP_READ: op_in = OP_READ_W;
                  A_SHOW: op_in = OP_COPY;
                  default: op_in = OP_READ_D;
               endcase
               case (req_data.action)
                  A_PIX_SET, A_PIX_ADD, A_PIX_INV, A_DISP_READ: begin
                     if ((CNT_W'(req_data.row) < rows_act) &&
                         (CNT_W'(req_data.col) < cols_act)) begin
                        y_in       = CNT_W'(req_data.row);
                        y_end_in   = CNT_W'(req_data.row) + CNT_W'(1);
                        x_in       = CNT_W'(req_data.col);
                        x_start_in = CNT_W'(req_data.col);
                        x_end_in   = CNT_W'(req_data.col) + CNT_W'(1);
                     end
                  end
                  A_ROW_SET, A_ROW_ADD, A_ROW_INV: begin
                     if (CNT_W'(req_data.row) < rows_act) begin
                        y_in       = CNT_W'(req_data.row);
                        y_end_in   = CNT_W'(req_data.row) + CNT_W'(1);
                        x_in       = rng_lo;
                        x_start_in = rng_lo;
                        x_end_in   = rng_hi;
                     end
                  end
                  A_COL_SET, A_COL_ADD, A_COL_INV: begin
                     if (CNT_W'(req_data.col) < cols_act) begin
                        y_in       = rng_lo;
                        y_end_in   = rng_hi;
                        x_in       = CNT_W'(req_data.col);
                        x_start_in = CNT_W'(req_data.col);
                        x_end_in   = CNT_W'(req_data.col) + CNT_W'(1);
                     end
                  end
                  A_STRIP_SET, A_STRIP_READ: begin
                     rem_in   = req_data.strip_index;
                     state_in = S_DIV;
                  end
                  default: begin
                     y_end_in = rows_act;
                     x_end_in = cols_act;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (rem_ff < IDX_W'(cols_act)) begin
               y_end_in   = y_ff + CNT_W'(1);
               x_in       = strip_col;
               x_start_in = strip_col;
               x_end_in   = strip_col + CNT_W'(1);
               state_in   = S_SCAN;
            end else if ((y_ff + CNT_W'(1)) >= rows_act) begin
               y_in     = '0;
               y_end_in = '0;
               state_in = S_SCAN;
            end else begin
               rem_in = rem_ff - IDX_W'(cols_act);
               y_in   = y_ff + CNT_W'(1);
            end
         end
         S_SCAN: begin
            if (issue) begin
               pend_valid_in = 1'b1;
               if (x_wrap) begin
                  x_in = x_start_ff;
                  y_in = y_ff + CNT_W'(1);
               end else begin
                  x_in = x_ff + CNT_W'(1);
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_strobe_in = 1'b1;
            rsp_data_in   = rd_ff;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // per-channel update of the pending pixel
   always_comb begin
      pix_new = '0;
      for (int k = 0; k < 3; k++) begin
         cur = work_rd_ff[k*CH_W +: CH_W];
         opv = opnd_ff[k*CH_W +: CH_W];
         sum = {1'b0, cur} + {1'b0, opv};
         case (op_ff)
            OP_SET:  pix_new[k*CH_W +: CH_W] = opv;
            OP_ADD:  pix_new[k*CH_W +: CH_W] = sum[CH_W] ? '1 : sum[CH_W-1:0];
            default: pix_new[k*CH_W +: CH_W] = ~cur;
         endcase
      end
   end

   always_comb begin
      rd_in = rd_ff;
      if (accept) rd_in = '0;
      else if (pend_valid_ff && (op_ff == OP_READ_W)) rd_in = work_rd_ff;
      else if (pend_valid_ff && (op_ff == OP_READ_D)) rd_in = disp_rd_ff;
   end

   assign work_we    = (state_ff == S_CLEAR) ||
                       (pend_valid_ff && ((op_ff == OP_SET) || (op_ff == OP_ADD) ||
                                          (op_ff == OP_INV)));
   assign disp_we    = (state_ff == S_CLEAR) || (pend_valid_ff && (op_ff == OP_COPY));
   assign wr_addr    = (state_ff == S_CLEAR) ? clr_ff : pend_addr_ff;
   assign work_wdata = (state_ff == S_CLEAR) ? '0 : pix_new;
   assign disp_wdata = (state_ff == S_CLEAR) ? '0 : work_rd_ff;

   always_ff @(posedge clock) begin
      if (work_we) work_mem[wr_addr] <= work_wdata;
      work_rd_ff <= work_mem[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (disp_we) disp_mem[wr_addr] <= disp_wdata;
      disp_rd_ff <= disp_mem[scan_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      rem_ff       <= rem_in;
      y_ff         <= y_in;
      y_end_ff     <= y_end_in;
      x_ff         <= x_in;
      x_start_ff   <= x_start_in;
      x_end_ff     <= x_end_in;
      opnd_ff      <= opnd_in;
      rd_ff        <= rd_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- hdl/lmfe_checker.sv -----
// Port-level checker for the frame engine, bound to the top level.
`include "led_matrix_frame_engine_macros.svh"

module lmfe_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   `LMFE_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
   `LMFE_ASSERT_NOW(a_strobe_idle, rsp_strobe, !busy, "result beat while still busy")
   `LMFE_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result beats back to back")
   `LMFE_ASSERT_NEXT(a_no_early_rsp, start && !busy, !rsp_strobe, "result beat right after start")

endmodule

bind led_matrix_frame_engine lmfe_checker u_lmfe_checker (.*);
